FILE: design/trie_dictionary_lookup_macros.svh
// Assertion macros shared by the trie lookup modules.
`ifndef TRIE_DICTIONARY_LOOKUP_MACROS_SVH
`define TRIE_DICTIONARY_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TDL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdl assertion failed");
// next-cycle implication
`define TDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdl assertion failed");
`else
`define TDL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TDL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/tdl_pkg.sv
package tdl_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int ALPHABET_SIZE = 27;
  localparam int COUNT_WIDTH   = 20;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int USED_W = NODE_W + 1;
  localparam int SLOT_W = $clog2(ALPHABET_SIZE);
  localparam int ROW_W  = ALPHABET_SIZE * NODE_W + 1;

  localparam logic [7:0] CH_LA   = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ   = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UA   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ   = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] APOS_OFFSET = 8'd13;

  typedef logic [NODE_W-1:0] link_t;

  // one node: word mark plus one child link per slot
  typedef struct packed {
    logic                           mark;
    link_t [ALPHABET_SIZE-1:0]      links;
  } row_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_ILLEGAL = 2'd1,
    ERR_FULL    = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_ALLOC
  } state_e;

  typedef struct packed {
    logic init;     // clear root row after reset
    logic capture;  // latch the incoming item
    logic exec;     // act on the item, node row is on the read port
    logic alloc;    // clear the new node's row
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_alloc;
  } dp_stat_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  function automatic slot_t slot_of(input logic [7:0] c, input logic fold);
    slot_t s;
    s.ok  = 1'b0;
    s.idx = '0;
    if (c >= CH_LA && c <= CH_LZ) begin
      s.ok  = 1'b1;
      s.idx = SLOT_W'(c - CH_LA);
    end else if (fold && c >= CH_UA && c <= CH_UZ) begin
      s.ok  = 1'b1;
      s.idx = SLOT_W'(c - CH_UA);
    end else if (c == CH_APOS) begin
      s.ok  = 1'b1;
      s.idx = SLOT_W'(c - APOS_OFFSET);
    end
    return s;
  endfunction

endpackage

FILE: design/tdl_ram.sv
module tdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tdl_ctrl.sv
`include "trie_dictionary_lookup_macros.svh"

module tdl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output tdl_pkg::ctrl_cmd_t cmd,
  input  tdl_pkg::dp_stat_t  stat
);
  import tdl_pkg::*;

  state_e state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = stat.need_alloc ? S_ALLOC : S_IDLE;
      S_ALLOC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    finish = 1'b0;
    unique case (state_r)
      S_INIT:  cmd.init = 1'b1;
      S_IDLE:  cmd.capture = start;
      S_EXEC: begin
        cmd.exec = 1'b1;
        finish   = !stat.need_alloc;
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        finish    = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = finish;
  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;

  `TDL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `TDL_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid, !out_valid)
  `TDL_ASSERT_IMPLY(a_alloc_from_exec, clk, rst_n, state_r == S_ALLOC, $past(state_r) == S_EXEC)

endmodule

FILE: design/tdl_dp.sv
`include "trie_dictionary_lookup_macros.svh"

module tdl_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tdl_pkg::ctrl_cmd_t                 cmd,
  output tdl_pkg::dp_stat_t                  stat,
  input  logic [1:0]                         in_command,
  input  logic [7:0]                         in_ch,
  output logic                               out_answer_valid,
  output logic                               out_found,
  output logic [1:0]                         out_error,
  output logic [tdl_pkg::COUNT_WIDTH-1:0]    out_word_total,
  output logic                               out_is_loaded
);
  import tdl_pkg::*;

  // held item
  cmd_e       item_cmd_r, item_cmd_nxt;
  logic [7:0] item_ch_r, item_ch_nxt;

  // trie walk state
  link_t                  cur_r, cur_nxt;
  logic [USED_W-1:0]      used_r, used_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   done_r, done_nxt;
  logic                   failed_r, failed_nxt;
  logic                   dead_r, dead_nxt;

  // result fields
  logic       ans_r, ans_nxt;
  logic       found_r, found_nxt;
  logic [1:0] err_r, err_nxt;

  // memory port
  logic              mem_we;
  link_t             mem_waddr;
  row_t              wr_row;
  logic [ROW_W-1:0]  mem_rdata;
  row_t              rd_row;

  slot_t             slot;
  logic [SLOT_W-1:0] slot_idx;
  link_t             link;
  link_t             new_node;
  logic              table_full;

  tdl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NODE_COUNT)
  ) u_rows (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(wr_row),
    .raddr(cur_r),
    .rdata(mem_rdata)
  );

  assign rd_row     = row_t'(mem_rdata);
  assign slot       = slot_of(item_ch_r, item_cmd_r == CMD_LOOKUP);
  assign slot_idx   = slot.ok ? slot.idx : '0;
  assign link       = rd_row.links[slot_idx];
  assign new_node   = used_r[NODE_W-1:0];
  assign table_full = (used_r >= USED_W'(NODE_COUNT));

  assign stat.need_alloc = (item_cmd_r == CMD_INSERT) && !failed_r && !done_r &&
                           (item_ch_r != CH_NL) && slot.ok && (link == '0) &&
                           !table_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      used_r   <= USED_W'(1);
      count_r  <= '0;
      done_r   <= 1'b0;
      failed_r <= 1'b0;
      dead_r   <= 1'b0;
      ans_r    <= 1'b0;
      found_r  <= 1'b0;
      err_r    <= ERR_NONE;
    end else begin
      cur_r    <= cur_nxt;
      used_r   <= used_nxt;
      count_r  <= count_nxt;
      done_r   <= done_nxt;
      failed_r <= failed_nxt;
      dead_r   <= dead_nxt;
      ans_r    <= ans_nxt;
      found_r  <= found_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_cmd_r <= item_cmd_nxt;
    item_ch_r  <= item_ch_nxt;
  end

  always_comb begin
    item_cmd_nxt = item_cmd_r;
    item_ch_nxt  = item_ch_r;
    cur_nxt      = cur_r;
    used_nxt     = used_r;
    count_nxt    = count_r;
    done_nxt     = done_r;
    failed_nxt   = failed_r;
    dead_nxt     = dead_r;
    ans_nxt      = ans_r;
    found_nxt    = found_r;
    err_nxt      = err_r;
    mem_we       = 1'b0;
    mem_waddr    = cur_r;
    wr_row       = '0;

    if (cmd.init) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
    end

    if (cmd.capture) begin
      item_cmd_nxt = cmd_e'(in_command);
      item_ch_nxt  = in_ch;
    end

    if (cmd.exec) begin
      ans_nxt   = 1'b0;
      found_nxt = 1'b0;
      err_nxt   = ERR_NONE;
      unique case (item_cmd_r)
        CMD_INSERT: begin
          if (!failed_r && !done_r) begin
            if (item_ch_r == CH_NL) begin
              mem_we      = 1'b1;
              wr_row      = rd_row;
              wr_row.mark = 1'b1;
              if (count_r != '1) count_nxt = count_r + 1'b1;
              cur_nxt = '0;
            end else if (!slot.ok) begin
              failed_nxt = 1'b1;
              err_nxt    = ERR_ILLEGAL;
            end else if (link != '0) begin
              cur_nxt = link;
            end else if (table_full) begin
              failed_nxt = 1'b1;
              err_nxt    = ERR_FULL;
            end else begin
              // hook the new node in; its row is cleared next cycle
              mem_we                 = 1'b1;
              wr_row                 = rd_row;
              wr_row.links[slot_idx] = new_node;
            end
          end
        end
        CMD_LOOKUP: begin
          if (item_ch_r == CH_NUL) begin
            ans_nxt   = 1'b1;
            found_nxt = !dead_r && rd_row.mark;
            cur_nxt   = '0;
            dead_nxt  = 1'b0;
          end else if (!dead_r) begin
            if (!slot.ok || link == '0) begin
              dead_nxt = 1'b1;
            end else begin
              cur_nxt = link;
            end
          end
        end
        CMD_CLEAR: begin
          // other rows are cleared as they get allocated
          mem_we     = 1'b1;
          mem_waddr  = '0;
          cur_nxt    = '0;
          used_nxt   = USED_W'(1);
          count_nxt  = '0;
          done_nxt   = 1'b0;
          failed_nxt = 1'b0;
          dead_nxt   = 1'b0;
        end
        CMD_END: begin
          if (!failed_r) done_nxt = 1'b1;
          cur_nxt = '0;
        end
        default: cur_nxt = cur_r;
      endcase
    end

    if (cmd.alloc) begin
      mem_we    = 1'b1;
      mem_waddr = new_node;
      cur_nxt   = new_node;
      used_nxt  = used_r + 1'b1;
    end
  end

  assign out_answer_valid = ans_r;
  assign out_found        = found_r;
  assign out_error        = err_r;
  assign out_word_total   = done_r ? count_r : '0;
  assign out_is_loaded    = done_r;

  `TDL_ASSERT_NEXT(a_alloc_count, clk, rst_n, cmd.alloc, used_r == $past(used_r) + 1'b1)
  `TDL_ASSERT_IMPLY(a_err_fails, clk, rst_n, err_r != ERR_NONE, failed_r)
  `TDL_ASSERT_IMPLY(a_done_clean, clk, rst_n, done_r, !failed_r)
  `TDL_ASSERT_IMPLY(a_used_range, clk, rst_n, 1'b1, used_r != '0 && used_r <= USED_W'(NODE_COUNT))

endmodule

FILE: design/trie_dictionary_lookup.sv
// Channel   Handshake            Payload
// input     start / busy         in_command, in_ch
// result    out_valid (strobe)   out_answer_valid, out_found, out_error,
//                                out_word_total, out_is_loaded
//
// Each item first reads the current node's row from the node RAM, then acts on
// it. An insert that allocates a node adds a further step that clears the new
// node's row on the single write port.
// The result strobes for one cycle right after the item finishes; busy is
// already low then, so the next item may be accepted in that cycle.
// After reset release the block is busy while it clears the root.
// The receiver cannot stall results.
module trie_dictionary_lookup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_command,
  input  logic [7:0]                      in_ch,
  output logic                            out_valid,
  output logic                            out_answer_valid,
  output logic                            out_found,
  output logic [1:0]                      out_error,
  output logic [tdl_pkg::COUNT_WIDTH-1:0] out_word_total,
  output logic                            out_is_loaded
);
  import tdl_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  tdl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (ctrl_cmd),
    .stat     (dp_stat)
  );

  tdl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat),
    .in_command      (in_command),
    .in_ch           (in_ch),
    .out_answer_valid(out_answer_valid),
    .out_found       (out_found),
    .out_error       (out_error),
    .out_word_total  (out_word_total),
    .out_is_loaded   (out_is_loaded)
  );

endmodule
